### src/sds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sds_pkg : shared types and constants of the SCAN disk scheduler
// Field widths, beat layouts, register indexes, controller states and the
// stop descriptor handed from the controller to the output stage.
// ----------------------------------------------------------------------------
package sds_pkg;

  localparam int unsigned PosW     = 16;
  localparam int unsigned MoveW    = 22;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 40;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 17;
  localparam int unsigned CylW     = 17;

  // Register indexes of the configuration channel
  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_HEAD = 2'd0,
    CFG_DISK_CYLS  = 2'd1,
    CFG_SWEEP_UP   = 2'd2
  } cfg_reg_e;

  // Controller states, one-hot
  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_INS     = 8'b0000_0010,
    S_PLACE   = 8'b0000_0100,
    S_SPL_RD  = 8'b0000_1000,
    S_SPL_CHK = 8'b0001_0000,
    S_RUN_RD  = 8'b0010_0000,
    S_RUN_OUT = 8'b0100_0000,
    S_END     = 8'b1000_0000
  } state_e;

  // One stop of the schedule, before travel is accumulated
  typedef struct packed {
    logic [PosW-1:0] pos;
    logic            at_end;
    logic            dropped;
    logic            final_stop;
  } stop_t;

endpackage

### src/scan_disk_scheduler_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scan_disk_scheduler_core : SCAN (elevator) disk scheduler
// Collects a batch of cylinder requests, keeps them sorted in a RAM, and
// on the closing request streams out the SCAN service order.
// ----------------------------------------------------------------------------
// Usage:
//  - Slave stream: one request per beat, tdata = cylinder, tlast closes the
//    batch. Requests past MAX_REQUESTS are dropped and flag the batch.
//  - Master stream: one stop per beat; tdata = position, total_movement,
//    dropped; tuser = at_disk_end; tlast marks the final stop.
//  - Config channel: index/data writes of start_head, disk_cylinders and
//    sweep_up, always ready; write only while the block is idle.
//  - A request is stored by a sorted insert: every stored entry larger
//    than it shifts up one RAM entry per cycle through the single read
//    and single write port, then the new entry is placed. Into an empty
//    store it is placed directly; a dropped request is not stored.
//  - A closing request then locates the split by reading each stored
//    entry below start_head and closing the search, then emits each
//    request stop (RAM read, then load of the output register) and the
//    disk end stop after the end check of the first run. A batch of n
//    stored requests yields n + 1 stops.
//  - If the receiver stalls, the output register holds the beat and the
//    sweep waits on it; no stop is lost.
//  - Reset clears the batch count, the overflow flag, head and travel
//    state and restores the register defaults. The RAM is not cleared:
//    only entries written in the current batch are ever read.
// ----------------------------------------------------------------------------
module scan_disk_scheduler_core
  import sds_pkg::*;
#(
  parameter int unsigned MAX_REQUESTS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // request stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // cylinder[15:0]
  input  logic                s_axis_tlast,
  // stop stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // position[15:0], total_movement[37:16],
                                              // dropped[38], zero[39]
  output logic                m_axis_tuser,   // at_disk_end
  output logic                m_axis_tlast,
  // configuration writes
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned CW = $clog2(MAX_REQUESTS + 1);
  localparam int unsigned AW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam logic [CW-1:0] MaxCount = CW'(MAX_REQUESTS);

  // Configuration registers
  logic [PosW-1:0] start_head_q;
  logic [CylW-1:0] disk_cyls_q;
  logic            sweep_up_q;

  // Controller state
  state_e          state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic            ovf_q, ovf_d;
  logic [PosW-1:0] cyl_q, cyl_d;
  logic            last_q, last_d;
  logic [AW-1:0]   j_q, j_d;
  logic [CW-1:0]   ptr_q, ptr_d;
  logic [CW-1:0]   split_q, split_d;
  logic            phase_q, phase_d;

  // RAM ports
  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [PosW-1:0] ram_wdata, ram_rdata;

  // Output stage hookup
  logic            sg_init, sg_load, sg_free;
  stop_t           sg_stop;

  logic            in_beat;
  logic            run_asc, run_empty, second_empty;
  logic [PosW-1:0] outer_cyl;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_head_q <= '0;
      disk_cyls_q  <= CylW'(65536);
      sweep_up_q   <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_START_HEAD: start_head_q <= cfg_data_i[PosW-1:0];
        CFG_DISK_CYLS:  disk_cyls_q  <= cfg_data_i;
        CFG_SWEEP_UP:   sweep_up_q   <= cfg_data_i[0];
        default: ;  // unused index, ignore
      endcase
    end
  end

  // Outer end: zero cylinders count as one, anything above 64Ki saturates.
  assign outer_cyl = (disk_cyls_q == '0) ? '0 :
                     disk_cyls_q[CylW-1] ? {PosW{1'b1}} :
                     (disk_cyls_q[PosW-1:0] - PosW'(1));

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_beat       = s_axis_tvalid && s_axis_tready;

  // Direction of the run in progress: first run follows sweep_up, second reverses.
  assign run_asc      = sweep_up_q ^ phase_q;
  assign run_empty    = run_asc ? (ptr_q == count_q) : (ptr_q == '0);
  assign second_empty = sweep_up_q ? (split_q == '0) : (split_q == count_q);

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    ovf_d     = ovf_q;
    cyl_d     = cyl_q;
    last_d    = last_q;
    j_d       = j_q;
    ptr_d     = ptr_q;
    split_d   = split_q;
    phase_d   = phase_q;
    ram_we    = 1'b0;
    ram_waddr = j_q;
    ram_wdata = cyl_q;
    ram_re    = 1'b0;
    ram_raddr = '0;
    sg_init   = 1'b0;
    sg_load   = 1'b0;
    sg_stop   = '{pos: ram_rdata, at_end: 1'b0, dropped: ovf_q, final_stop: 1'b0};

    unique case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          cyl_d  = s_axis_tdata[PosW-1:0];
          last_d = s_axis_tlast;
          if (count_q < MaxCount) begin
            if (count_q == '0) begin
              // empty store: place directly
              ram_we    = 1'b1;
              ram_waddr = '0;
              ram_wdata = s_axis_tdata[PosW-1:0];
              count_d   = count_q + CW'(1);
              if (s_axis_tlast) begin
                sg_init = 1'b1;
                ptr_d   = '0;
                state_d = S_SPL_RD;
              end
            end else begin
              // start the shift walk at the top entry
              j_d       = count_q[AW-1:0];
              ram_re    = 1'b1;
              ram_raddr = AW'(count_q - CW'(1));
              state_d   = S_INS;
            end
          end else begin
            // store full: drop and flag
            ovf_d = 1'b1;
            if (s_axis_tlast) begin
              sg_init = 1'b1;
              ptr_d   = '0;
              state_d = S_SPL_RD;
            end
          end
        end
      end

      S_INS: begin
        ram_we = 1'b1;
        if (ram_rdata > cyl_q) begin
          // shift entry j-1 up to j, keep walking down
          ram_waddr = j_q;
          ram_wdata = ram_rdata;
          j_d       = j_q - AW'(1);
          if (j_q == AW'(1)) begin
            state_d = S_PLACE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = j_q - AW'(2);
          end
        end else begin
          ram_waddr = j_q;
          ram_wdata = cyl_q;
          count_d   = count_q + CW'(1);
          if (last_q) begin
            sg_init = 1'b1;
            ptr_d   = '0;
            state_d = S_SPL_RD;
          end else begin
            state_d = S_IDLE;
          end
        end
      end

      S_PLACE: begin
        ram_we    = 1'b1;
        ram_waddr = j_q;
        ram_wdata = cyl_q;
        count_d   = count_q + CW'(1);
        if (last_q) begin
          sg_init = 1'b1;
          ptr_d   = '0;
          state_d = S_SPL_RD;
        end else begin
          state_d = S_IDLE;
        end
      end

      S_SPL_RD: begin
        if (ptr_q == count_q) begin
          split_d = ptr_q;
          phase_d = 1'b0;
          state_d = S_RUN_RD;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = ptr_q[AW-1:0];
          state_d   = S_SPL_CHK;
        end
      end

      S_SPL_CHK: begin
        if (ram_rdata < start_head_q) begin
          ptr_d   = ptr_q + CW'(1);
          state_d = S_SPL_RD;
        end else begin
          split_d = ptr_q;
          phase_d = 1'b0;
          state_d = S_RUN_RD;
        end
      end

      S_RUN_RD: begin
        if (run_empty) begin
          state_d = S_END;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = run_asc ? ptr_q[AW-1:0] : AW'(ptr_q - CW'(1));
          state_d   = S_RUN_OUT;
        end
      end

      S_RUN_OUT: begin
        if (sg_free) begin
          sg_load            = 1'b1;
          sg_stop.final_stop = phase_q &&
                               (run_asc ? ((ptr_q + CW'(1)) == count_q) : (ptr_q == CW'(1)));
          ptr_d              = run_asc ? (ptr_q + CW'(1)) : (ptr_q - CW'(1));
          if (sg_stop.final_stop) begin
            count_d = '0;
            ovf_d   = 1'b0;
            state_d = S_IDLE;
          end else begin
            state_d = S_RUN_RD;
          end
        end
      end

      S_END: begin
        if (sg_free) begin
          sg_load            = 1'b1;
          sg_stop.pos        = sweep_up_q ? outer_cyl : '0;
          sg_stop.at_end     = 1'b1;
          sg_stop.final_stop = second_empty;
          ptr_d              = split_q;
          phase_d            = 1'b1;
          if (second_empty) begin
            count_d = '0;
            ovf_d   = 1'b0;
            state_d = S_IDLE;
          end else begin
            state_d = S_RUN_RD;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      ovf_q   <= 1'b0;
      last_q  <= 1'b0;
      j_q     <= '0;
      ptr_q   <= '0;
      split_q <= '0;
      phase_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
      last_q  <= last_d;
      j_q     <= j_d;
      ptr_q   <= ptr_d;
      split_q <= split_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cyl_q <= cyl_d;
  end

  sds_ram #(
    .WIDTH(PosW),
    .DEPTH(MAX_REQUESTS)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  sds_stop_gen u_stop_gen (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .init_i       (sg_init),
    .start_head_i (start_head_q),
    .load_i       (sg_load),
    .stop_i       (sg_stop),
    .free_o       (sg_free),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

`ifndef SYNTH
  // Batch never holds more entries than the store
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MaxCount)
    else $error("request count exceeds store depth");

  // Store is written only while inserting
  a_write_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_IDLE || state_q == S_INS || state_q == S_PLACE))
    else $error("store written outside insertion");

  // A stop is never loaded over an untaken beat
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sg_load |-> sg_free)
    else $error("stop loaded into occupied output register");

  // Final stop closes the batch
  a_final_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sg_load && sg_stop.final_stop) |=> (count_q == '0 && !ovf_q && state_q == S_IDLE))
    else $error("batch state not cleared after final stop");
`endif

endmodule

### src/sds_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sds_ram : generic simple dual-port RAM
// One write port, one read port, read data registered.
// Read data holds while no read is issued.
// ----------------------------------------------------------------------------
module sds_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/sds_stop_gen.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sds_stop_gen : head travel accumulator and output register
// Tracks the head position and the running travel sum, and holds one
// result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module sds_stop_gen
  import sds_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                init_i,
  input  logic [PosW-1:0]     start_head_i,
  input  logic                load_i,
  input  stop_t               stop_i,
  output logic                free_o,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,  // position, total_movement, dropped, pad
  output logic                m_axis_tuser,  // at_disk_end
  output logic                m_axis_tlast
);

  logic [PosW-1:0]  head_q, head_d;
  logic [MoveW-1:0] sum_q, sum_d;
  logic             valid_q, valid_d;
  logic [PosW-1:0]  pos_q;
  logic [MoveW-1:0] mov_q;
  logic             end_q, drop_q, fin_q;
  logic [PosW-1:0]  travel;

  assign free_o = !valid_q || m_axis_tready;

  assign travel = (stop_i.pos > head_q) ? (stop_i.pos - head_q) : (head_q - stop_i.pos);

  always_comb begin
    head_d  = head_q;
    sum_d   = sum_q;
    valid_d = valid_q;
    if (m_axis_tready) begin
      valid_d = 1'b0;
    end
    if (init_i) begin
      head_d = start_head_i;
      sum_d  = '0;
    end else if (load_i) begin
      head_d  = stop_i.pos;
      sum_d   = sum_q + MoveW'(travel);
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      sum_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      head_q  <= head_d;
      sum_q   <= sum_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && !init_i) begin
      pos_q  <= stop_i.pos;
      mov_q  <= sum_d;
      end_q  <= stop_i.at_end;
      drop_q <= stop_i.dropped;
      fin_q  <= stop_i.final_stop;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {1'b0, drop_q, mov_q, pos_q};
  assign m_axis_tuser  = end_q;
  assign m_axis_tlast  = fin_q;

endmodule
